// ===== hw/rtl/smx_pkg.sv =====
// ---------------------------------------------------------------------------
// smx_pkg
// Shared constants, opcodes and types of the stack machine execute unit.
// ---------------------------------------------------------------------------
package smx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int MAX_PROGRAM = 65536;
    localparam int SP_W        = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int PC_W        = 17;
    localparam int OP_W        = 4;
    localparam int ARG_W       = 64;
    localparam int ERR_W       = 3;
    localparam int KIND_W      = 2;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 152;

    localparam logic [OP_W-1:0] OP_PRINT = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_EXIT  = 4'd2;
    localparam logic [OP_W-1:0] OP_POP   = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd5;
    localparam logic [OP_W-1:0] OP_EQ    = 4'd6;
    localparam logic [OP_W-1:0] OP_NEQ   = 4'd7;
    localparam logic [OP_W-1:0] OP_DUP   = 4'd8;
    localparam logic [OP_W-1:0] OP_JMP   = 4'd9;
    localparam logic [OP_W-1:0] OP_JMPZ  = 4'd10;
    localparam logic [OP_W-1:0] OP_WRITE = 4'd11;
    localparam logic [OP_W-1:0] OP_WCHAR = 4'd12;

    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DIV0  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_PC    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVER  = 3'd4;

    localparam logic [KIND_W-1:0] EMIT_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EMIT_PRINT = 2'd1;
    localparam logic [KIND_W-1:0] EMIT_WRITE = 2'd2;
    localparam logic [KIND_W-1:0] EMIT_CHAR  = 2'd3;

    // decoded instruction, front to back
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ARG_W-1:0] argument;
        logic [1:0]       need;
        logic             pushes;
        logic             chk_target;
    } smx_instr_t;

endpackage

// ===== hw/rtl/smx_ram.sv =====
// ---------------------------------------------------------------------------
// smx_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== hw/rtl/smx_front.sv =====
// ---------------------------------------------------------------------------
// smx_front
// Accepts instructions, decodes their stack needs, two-entry queue to back.
// ---------------------------------------------------------------------------
module smx_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [smx_pkg::OP_W-1:0]  in_op,
    input  logic [smx_pkg::ARG_W-1:0] in_arg,
    output logic                    q_valid,
    output smx_pkg::smx_instr_t     q_instr,
    input  logic                    q_pop
);
    import smx_pkg::*;

    smx_instr_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    smx_instr_t dec;
    logic       push;

    always_comb begin
        dec            = '0;
        dec.op         = in_op;
        dec.argument   = in_arg;
        case (in_op)
            OP_PRINT, OP_EXIT, OP_POP, OP_WRITE, OP_WCHAR: dec.need = 2'd1;
            OP_JMPZ: begin
                dec.need = 2'd1;
                dec.chk_target = 1'b1;
            end
            OP_DUP: begin
                dec.need = 2'd1;
                dec.pushes = 1'b1;
            end
            OP_ADD, OP_DIV, OP_EQ, OP_NEQ: dec.need = 2'd2;
            OP_LOAD: dec.pushes = 1'b1;
            OP_JMP: dec.chk_target = 1'b1;
            default: dec.need = 2'd0;
        endcase
    end

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_instr  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end
endmodule

// ===== hw/rtl/smx_div.sv =====
// ---------------------------------------------------------------------------
// smx_div
// Signed 64-bit truncating divider, restoring, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module smx_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [smx_pkg::ARG_W-1:0] dividend,
    input  logic [smx_pkg::ARG_W-1:0] divisor,
    output logic                      done,
    output logic [smx_pkg::ARG_W-1:0] quotient
);
    import smx_pkg::*;

    localparam int STEP_W = $clog2(ARG_W + 1);

    logic [ARG_W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [ARG_W:0]    shifted, diff;

    assign shifted  = {rem_reg, quo_reg[ARG_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign done     = busy_reg && (step_reg == STEP_W'(0));
    assign quotient = neg_reg ? (ARG_W'(0) - quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= dividend[ARG_W-1] ? (ARG_W'(0) - dividend) : dividend;
            dvs_reg  <= divisor[ARG_W-1] ? (ARG_W'(0) - divisor) : divisor;
            neg_reg  <= dividend[ARG_W-1] ^ divisor[ARG_W-1];
            step_reg <= STEP_W'(ARG_W);
        end else if (busy_reg && step_reg != STEP_W'(0)) begin
            if (!diff[ARG_W]) begin
                rem_reg <= diff[ARG_W-1:0];
            end else begin
                rem_reg <= shifted[ARG_W-1:0];
            end
            quo_reg  <= {quo_reg[ARG_W-2:0], ~diff[ARG_W]};
            step_reg <= step_reg - STEP_W'(1);
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (done) begin
            busy_reg <= 1'b0;
        end
    end
endmodule

// ===== hw/rtl/smx_back.sv =====
// ---------------------------------------------------------------------------
// smx_back
// Executes decoded instructions against the operand stack; top in a register,
// the rest in RAM; builds the result item in an output register.
// ---------------------------------------------------------------------------
module smx_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  smx_pkg::smx_instr_t         q_instr,
    output logic                        q_pop,
    input  logic [smx_pkg::PC_W-1:0]    prog_len,
    output logic                        out_valid,
    output logic [smx_pkg::OUT_W-1:0]   out_data,
    input  logic                        out_ready
);
    import smx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DIV  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    smx_instr_t        cur_reg;
    logic [ARG_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic              halt_reg, halt_next;
    logic              ov_reg, ov_next;
    logic [OUT_W-1:0]  od_reg, od_next;

    logic              wr_en;
    logic [SP_W-1:0]   wr_addr, rd_addr;
    logic [ARG_W-1:0]  second;
    logic              div_start, div_done;
    logic [ARG_W-1:0]  div_q;
    logic [PC_W-1:0]   bound, pc_inc;
    logic              target_ok;
    logic [ERR_W-1:0]  err;
    logic [KIND_W-1:0] kind;
    logic [ARG_W-1:0]  emit;

    smx_ram #(.WIDTH(ARG_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(top_reg),
        .rd_addr(rd_addr),
        .rd_data(second)
    );

    smx_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(second),
        .divisor (top_reg),
        .done    (div_done),
        .quotient(div_q)
    );

    // entry below top sits at count-2, the old top is spilled at count-1
    assign rd_addr = SP_W'(q_instr.need == 2'd0 ? cnt_reg : cnt_reg - CNT_W'(2));
    assign wr_addr = SP_W'(cnt_reg - CNT_W'(1));
    assign bound   = (prog_len > PC_W'(MAX_PROGRAM)) ? PC_W'(MAX_PROGRAM) : prog_len;
    assign target_ok = (cur_reg.argument[ARG_W-1:PC_W] == '0)
                    && (cur_reg.argument[PC_W-1:0] < bound);
    assign pc_inc  = pc_reg + PC_W'(1);
    assign q_pop   = (state_reg == S_IDLE) && q_valid && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb begin
        err = ERR_NONE;
        if (cnt_reg < CNT_W'(cur_reg.need)) begin
            err = ERR_UNDER;
        end else if (cur_reg.chk_target && !target_ok) begin
            err = ERR_PC;
        end else if (cur_reg.op == OP_DIV && top_reg == '0) begin
            err = ERR_DIV0;
        end else if (cur_reg.pushes && cnt_reg >= CNT_W'(STACK_DEPTH)) begin
            err = ERR_OVER;
        end
    end

    always_comb begin
        state_next = state_reg;
        top_next   = top_reg;
        cnt_next   = cnt_reg;
        pc_next    = pc_reg;
        halt_next  = halt_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        kind       = EMIT_NONE;
        emit       = '0;
        case (state_reg)
            S_IDLE: begin
                if (q_pop) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                if (halt_reg) begin
                    ov_next = 1'b1;
                    od_next = {1'b0, (cnt_reg == '0) ? ARG_W'(0) : top_reg, ARG_W'(0),
                               EMIT_NONE, ERR_NONE, 1'b1, pc_reg};
                end else if (err != ERR_NONE) begin
                    halt_next = 1'b1;
                    pc_next   = pc_inc;
                    ov_next   = 1'b1;
                    od_next   = {1'b0, (cnt_reg == '0) ? ARG_W'(0) : top_reg, ARG_W'(0),
                                 EMIT_NONE, err, 1'b1, pc_inc};
                end else if (cur_reg.op == OP_DIV) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else begin
                    pc_next = pc_inc;
                    case (cur_reg.op)
                        OP_PRINT: begin
                            kind = EMIT_PRINT;
                            emit = top_reg;
                        end
                        OP_WRITE: begin
                            kind = EMIT_WRITE;
                            emit = top_reg;
                        end
                        OP_WCHAR: begin
                            kind = EMIT_CHAR;
                            emit = {{(ARG_W-8){1'b0}}, top_reg[7:0]};
                        end
                        OP_LOAD: begin
                            wr_en    = (cnt_reg != '0);
                            top_next = cur_reg.argument;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        OP_DUP: begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        OP_EXIT: halt_next = 1'b1;
                        OP_POP: begin
                            top_next = second;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        OP_ADD: begin
                            top_next = top_reg + second;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        OP_EQ: begin
                            top_next = ARG_W'(top_reg == second);
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        OP_NEQ: begin
                            top_next = ARG_W'(top_reg != second);
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                        OP_JMP: pc_next = cur_reg.argument[PC_W-1:0];
                        OP_JMPZ: begin
                            top_next = second;
                            cnt_next = cnt_reg - CNT_W'(1);
                            if (top_reg == '0) begin
                                pc_next = cur_reg.argument[PC_W-1:0];
                            end
                        end
                        default: pc_next = pc_inc;
                    endcase
                    ov_next = 1'b1;
                    od_next = {1'b0, (cnt_next == '0) ? ARG_W'(0) : top_next, emit, kind,
                               ERR_NONE, halt_next, pc_next};
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_IDLE;
                    top_next   = div_q;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    pc_next    = pc_inc;
                    ov_next    = 1'b1;
                    od_next    = {1'b0, div_q, ARG_W'(0), EMIT_NONE, ERR_NONE, 1'b0,
                                  pc_inc};
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_instr;
        end
        top_reg <= top_next;
        od_reg  <= od_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pc_reg    <= '0;
            halt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// ---------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack-machine instruction per item, one result item each.
// ---------------------------------------------------------------------------
// A result item follows its instruction through the input queue, whose
// pop doubles as the stack RAM read, then through the execute state.
// Divide also waits in a divide state for the bit-serial divider. Up to
// two instructions queue ahead of execution. The result register must be
// drained before the next instruction executes, so no instruction leaves
// the queue while a result item waits. No clearing pass after reset.
module stack_machine_execute_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // op[3:0], argument[67:4], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // next_pc[16:0], halted[17], error_code[20:18],
                                    // emit_kind[22:21], emit_value[86:23],
                                    // top_value[150:87], zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data   // program_length
);
    import smx_pkg::*;

    logic             q_valid, q_pop;
    smx_instr_t       q_instr;
    logic [PC_W-1:0]  prog_len_reg;
    logic [OUT_W-1:0] out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prog_len_reg <= PC_W'(1);
        end else if (cfg_valid) begin
            prog_len_reg <= cfg_data;
        end
    end

    smx_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_op   (s_tdata[3:0]),
        .in_arg  (s_tdata[67:4]),
        .q_valid (q_valid),
        .q_instr (q_instr),
        .q_pop   (q_pop)
    );

    smx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_instr  (q_instr),
        .q_pop    (q_pop),
        .prog_len (prog_len_reg),
        .out_valid(m_tvalid),
        .out_data (out_data),
        .out_ready(m_tready)
    );

    assign m_tdata = out_data;

    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20:18] != ERR_NONE |-> m_tdata[17])
        else $error("error result without halt");

    a_emit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[22:21] != EMIT_NONE |-> m_tdata[20:18] == ERR_NONE
        && !m_tdata[17])
        else $error("emit on error or halted");

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[17] ##1 m_tvalid |-> m_tdata[17])
        else $error("halt dropped");
endmodule

// ===== tb/stack_machine_execute_unit_tb.sv =====
// ---------------------------------------------------------------------------
// stack_machine_execute_unit_tb
// Self-checking bench for the stack machine execute unit: a directed table,
// then legal random instruction streams under several program lengths, and a
// final halting instruction followed by steps while halted. Every result item
// is checked against its row's typed result or a local stack machine model.
// ---------------------------------------------------------------------------
module stack_machine_execute_unit_tb;
    import smx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT   = 27;
    localparam int STALL_MAX  = 5000;
    localparam int RAND_ITEMS = 900;

    // last field in the lowest bits, as in m_tdata
    typedef struct packed {
        logic [ARG_W-1:0]  top;
        logic [ARG_W-1:0]  emit;
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic              halted;
        logic [PC_W-1:0]   next_pc;
    } exec_result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [ARG_W-1:0] arg;
        bit               typed;
        exec_result_t     res;
    } instr_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [16:0]  cfg_data = '0;

    // model state
    logic [ARG_W-1:0] stk [STACK_DEPTH];
    int               depth_cnt = 0;
    logic [PC_W-1:0]  pc = '0;
    bit               halt = 0;
    logic [16:0]      plen = 17'd1;

    exec_result_t expected_results[$];
    int  fail_cnt = 0;
    int  checked_cnt = 0;
    int  sent_cnt = 0;
    int  stall_cnt = 0;
    int  push_bias = 25;
    bit  burst = 0;
    int  max_depth = 0;

    stack_machine_execute_unit DUT (.*);

    always #5 aclk = ~aclk;

    function automatic logic [ARG_W-1:0] top_of();
        return (depth_cnt == 0) ? '0 : stk[depth_cnt-1];
    endfunction

    function automatic logic [ARG_W-1:0] trunc_div(logic [ARG_W-1:0] a, logic [ARG_W-1:0] b);
        logic [ARG_W-1:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic int pc_bound();
        return (plen < MAX_PROGRAM) ? int'(plen) : MAX_PROGRAM;
    endfunction

    function automatic exec_result_t execute_instr(logic [OP_W-1:0] op, logic [ARG_W-1:0] arg);
        exec_result_t r;
        logic [ERR_W-1:0] err;
        logic [ARG_W-1:0] t, s;
        int  need;
        bit  pushes, tgt_ok;
        r = '0;
        if (halt) begin
            r.next_pc = pc;
            r.halted  = 1'b1;
            r.top     = top_of();
            return r;
        end
        tgt_ok = !arg[63] && (arg < 64'(pc_bound()));
        need = 0;
        pushes = 0;
        case (op)
            OP_PRINT, OP_EXIT, OP_POP, OP_JMPZ, OP_WRITE, OP_WCHAR: need = 1;
            OP_DUP: begin need = 1; pushes = 1; end
            OP_ADD, OP_DIV, OP_EQ, OP_NEQ: need = 2;
            OP_LOAD: pushes = 1;
            default: ;
        endcase
        err = ERR_NONE;
        if (depth_cnt < need) err = ERR_UNDER;
        else if ((op == OP_JMP || op == OP_JMPZ) && !tgt_ok) err = ERR_PC;
        else if (op == OP_DIV && stk[depth_cnt-1] == '0) err = ERR_DIV0;
        else if (pushes && depth_cnt >= STACK_DEPTH) err = ERR_OVER;
        r.next_pc = pc + 1'b1;
        if (err != ERR_NONE) begin
            halt = 1;
        end else begin
            t = top_of();
            s = (depth_cnt >= 2) ? stk[depth_cnt-2] : '0;
            case (op)
                OP_PRINT: begin r.kind = EMIT_PRINT; r.emit = t; end
                OP_LOAD:  begin stk[depth_cnt] = arg; depth_cnt++; end
                OP_EXIT:  halt = 1;
                OP_POP:   depth_cnt--;
                OP_ADD:   begin depth_cnt--; stk[depth_cnt-1] = t + s; end
                OP_DIV:   begin depth_cnt--; stk[depth_cnt-1] = trunc_div(s, t); end
                OP_EQ:    begin depth_cnt--; stk[depth_cnt-1] = 64'(t == s); end
                OP_NEQ:   begin depth_cnt--; stk[depth_cnt-1] = 64'(t != s); end
                OP_DUP:   begin stk[depth_cnt] = t; depth_cnt++; end
                OP_JMP:   r.next_pc = arg[PC_W-1:0];
                OP_JMPZ:  begin
                    depth_cnt--;
                    if (t == '0) r.next_pc = arg[PC_W-1:0];
                end
                OP_WRITE: begin r.kind = EMIT_WRITE; r.emit = t; end
                OP_WCHAR: begin r.kind = EMIT_CHAR; r.emit = {56'd0, t[7:0]}; end
                default: ;
            endcase
        end
        if (depth_cnt > max_depth) max_depth = depth_cnt;
        pc = r.next_pc;
        r.halted = halt;
        r.err = err;
        r.top = top_of();
        return r;
    endfunction

    task automatic drive_instr(logic [OP_W-1:0] op, logic [ARG_W-1:0] arg,
                               bit typed = 0, exec_result_t res = '0);
        exec_result_t p;
        while (!burst && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, arg, op};
        do @(posedge aclk); while (!s_tready);
        p = execute_instr(op, arg);
        expected_results.push_back(typed ? res : p);
        sent_cnt++;
    endtask

    task automatic write_plen(logic [16:0] v);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        plen = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ARG_W-1:0] rand_arg();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '0;
            3: return '1;
            4: return 64'($signed($urandom_range(40)) - 20);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random instruction that neither halts nor faults in the current state
    task automatic drive_legal();
        logic [OP_W-1:0]  op;
        logic [ARG_W-1:0] arg;
        bit ok;
        do begin
            op  = ($urandom_range(99) < push_bias) ? OP_LOAD : OP_W'($urandom_range(15));
            arg = rand_arg();
            ok  = 1;
            case (op)
                OP_EXIT: ok = 0;
                OP_PRINT, OP_POP, OP_WRITE, OP_WCHAR: ok = depth_cnt >= 1;
                OP_ADD, OP_EQ, OP_NEQ: ok = depth_cnt >= 2;
                OP_DIV: ok = depth_cnt >= 2 && stk[depth_cnt-1] != '0;
                OP_LOAD: ok = depth_cnt < STACK_DEPTH;
                OP_DUP: ok = depth_cnt >= 1 && depth_cnt < STACK_DEPTH;
                OP_JMP, OP_JMPZ: begin
                    ok = pc_bound() > 0 && (op == OP_JMP || depth_cnt >= 1);
                    if (ok) arg = 64'($urandom_range(pc_bound() - 1));
                end
                default: ;
            endcase
        end while (!ok);
        drive_instr(op, arg);
    endtask

    // result side: random stalls, checking
    always @(posedge aclk) begin
        m_tready <= burst || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        exec_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[150:0];
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                fail_cnt++;
            end else begin
                exp_r = expected_results.pop_front();
                checked_cnt++;
                if (got.next_pc !== exp_r.next_pc) begin
                    $error("next_pc exp %0d got %0d", exp_r.next_pc, got.next_pc); fail_cnt++;
                end
                if (got.halted !== exp_r.halted) begin
                    $error("halted exp %0d got %0d", exp_r.halted, got.halted); fail_cnt++;
                end
                if (got.err !== exp_r.err) begin
                    $error("error_code exp %0d got %0d", exp_r.err, got.err); fail_cnt++;
                end
                if (got.kind !== exp_r.kind) begin
                    $error("emit_kind exp %0d got %0d", exp_r.kind, got.kind); fail_cnt++;
                end
                if (got.emit !== exp_r.emit) begin
                    $error("emit_value exp %h got %h", exp_r.emit, got.emit); fail_cnt++;
                end
                if (got.top !== exp_r.top) begin
                    $error("top_value exp %h got %h", exp_r.top, got.top); fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt == STALL_MAX) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        instr_row_t rows[$];
        logic [16:0] plens[$];
        int ending;
        rows = '{
            '{OP_LOAD,  64'h7FFF_FFFF_FFFF_FFFF, 1,
              '{64'h7FFF_FFFF_FFFF_FFFF, 0, EMIT_NONE, ERR_NONE, 0, 17'd1}},
            '{OP_LOAD,  64'h8000_0000_0000_0000, 1,
              '{64'h8000_0000_0000_0000, 0, EMIT_NONE, ERR_NONE, 0, 17'd2}},
            // max + min gives -1
            '{OP_ADD,   64'd0, 1, '{'1, 0, EMIT_NONE, ERR_NONE, 0, 17'd3}},
            '{OP_LOAD,  64'h8000_0000_0000_0000, 0, '0},
            '{OP_LOAD,  '1, 0, '0},
            // min / -1 wraps to min
            '{OP_DIV,   64'd0, 1,
              '{64'h8000_0000_0000_0000, 0, EMIT_NONE, ERR_NONE, 0, 17'd6}},
            '{OP_PRINT, 64'd0, 1,
              '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, EMIT_PRINT,
                ERR_NONE, 0, 17'd7}},
            '{OP_WRITE, 64'd0, 0, '0},
            '{OP_LOAD,  64'h1FF, 0, '0},
            '{OP_WCHAR, 64'd0, 0, '0},
            '{OP_DUP,   64'd0, 0, '0},
            '{OP_EQ,    64'd0, 0, '0},
            '{OP_NEQ,   64'd0, 0, '0},
            '{OP_POP,   64'd0, 0, '0},
            // only the -1 from the add is left
            '{OP_JMP,   64'd0, 1,
              '{'1, 0, EMIT_NONE, ERR_NONE, 0, 17'd0}},
            '{OP_LOAD,  64'd0, 0, '0},
            '{OP_JMPZ,  64'd0, 0, '0},   // zero popped: taken
            '{OP_LOAD,  64'd5, 0, '0},
            '{OP_JMPZ,  64'd0, 0, '0},   // nonzero popped: falls through
            '{OP_W'(13), '1, 0, '0},
            '{OP_W'(15), 64'd0, 0, '0},
            '{OP_LOAD,  64'd7, 0, '0},
            '{OP_LOAD,  -64'sd2, 0, '0},
            '{OP_DIV,   64'd0, 0, '0}    // truncates toward zero
        };
        plens = '{17'd65536, 17'd0, 17'h1FFFF, 17'd1, 17'd2,
                  17'($urandom_range(65536, 1))};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) drive_instr(rows[i].op, rows[i].arg, rows[i].typed, rows[i].res);

        foreach (plens[k]) begin
            write_plen(plens[k]);
            push_bias = (k % 2) ? 70 : 20;
            for (int i = 0; i < RAND_ITEMS / plens.size(); i++) begin
                burst = (k == 2 && i >= 20 && i < 120);
                drive_legal();
            end
            burst = 0;
        end
        write_plen(17'($urandom_range(300, 1)));

        // one halting instruction, then steps while halted
        ending = $urandom_range(4);
        case (ending)
            0: begin
                if (depth_cnt == 0) drive_instr(OP_LOAD, rand_arg());
                drive_instr(OP_EXIT, rand_arg());
            end
            1: begin
                while (depth_cnt > 0) drive_instr(OP_POP, '0);
                drive_instr(OP_POP, '0);
            end
            2: begin
                drive_instr(OP_LOAD, rand_arg());
                drive_instr(OP_LOAD, '0);
                drive_instr(OP_DIV, '0);
            end
            3: begin
                if (depth_cnt == 0) drive_instr(OP_LOAD, '0);
                drive_instr($urandom_range(1) ? OP_JMP : OP_JMPZ,
                            $urandom_range(1) ? 64'(pc_bound()) : '1);
            end
            default: begin
                while (depth_cnt < STACK_DEPTH) drive_instr(OP_LOAD, rand_arg());
                drive_instr($urandom_range(1) ? OP_LOAD : OP_DUP, rand_arg());
            end
        endcase
        repeat (6) drive_instr(OP_W'($urandom_range(15)), rand_arg());
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d instructions, checked %0d results, deepest stack %0d.",
                 sent_cnt, checked_cnt, max_depth);
        $display("Halting case %0d exercised; %0d mismatches.", ending, fail_cnt);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
